>>> hdl/gbs_pkg.sv
package gbs_pkg;

  localparam int CAPACITY  = 1024;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int MAX_KEPT  = 64;
  localparam int KEPT_W    = $clog2(MAX_KEPT + 1);
  localparam int THR_W     = 11;
  localparam logic [THR_W-1:0] THR_RESET = 11'd461;
  localparam int COORD_W   = 16;
  localparam int SCORE_W   = 16;
  localparam int LABEL_W   = 2;
  localparam int AREA_W    = 2 * COORD_W;
  localparam int UNION_W   = AREA_W + 1;
  localparam int PROD_W    = UNION_W + THR_W;
  localparam int TDATA_W   = 88;

  typedef struct packed {
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  typedef struct packed {
    box_t               box;
    logic [SCORE_W-1:0] score;
    logic [LABEL_W-1:0] label;
  } entry_t;

  typedef struct packed {
    logic done;
    logic hit;
  } iou_res_t;

endpackage

>>> hdl/gbs_iou.sv
module gbs_iou
  import gbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [THR_W-1:0] thr_i,
  input  box_t             box_a_i,
  input  box_t             box_b_i,
  output iou_res_t         res_o
);

  typedef enum logic [6:0] {
    I_IDLE   = 7'b0000001,
    I_AREA_A = 7'b0000010,
    I_AREA_B = 7'b0000100,
    I_INTER  = 7'b0001000,
    I_UNION  = 7'b0010000,
    I_PROD   = 7'b0100000,
    I_CMP    = 7'b1000000
  } iou_state_e;

  iou_state_e state_q, state_d;

  logic [AREA_W-1:0]  area_a_q, area_b_q, inter_q;
  logic [UNION_W-1:0] union_q;
  logic [PROD_W-1:0]  prod_q;

  logic [COORD_W-1:0] aw, ah, bw, bh, iw, ih;
  logic [COORD_W-1:0] ix1, iy1, ix2, iy2;
  logic [UNION_W-1:0] mul_a;
  logic [COORD_W-1:0] mul_b;
  logic [UNION_W+COORD_W-1:0] mul_p;

  function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                               input logic [COORD_W-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  always_comb begin
    ix1 = (box_a_i.left  > box_b_i.left)   ? box_a_i.left   : box_b_i.left;
    iy1 = (box_a_i.top   > box_b_i.top)    ? box_a_i.top    : box_b_i.top;
    ix2 = (box_a_i.right < box_b_i.right)  ? box_a_i.right  : box_b_i.right;
    iy2 = (box_a_i.bottom < box_b_i.bottom) ? box_a_i.bottom : box_b_i.bottom;
    aw  = span(box_a_i.left, box_a_i.right);
    ah  = span(box_a_i.top, box_a_i.bottom);
    bw  = span(box_b_i.left, box_b_i.right);
    bh  = span(box_b_i.top, box_b_i.bottom);
    iw  = span(ix1, ix2);
    ih  = span(iy1, iy2);
  end

  // one shared multiplier, operands picked by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      I_AREA_A: begin mul_a = UNION_W'(aw); mul_b = ah; end
      I_AREA_B: begin mul_a = UNION_W'(bw); mul_b = bh; end
      I_INTER:  begin mul_a = UNION_W'(iw); mul_b = ih; end
      I_PROD:   begin mul_a = union_q; mul_b = COORD_W'(thr_i); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = (UNION_W+COORD_W)'(mul_a) * (UNION_W+COORD_W)'(mul_b);
  end

  always_comb begin
    state_d = state_q;
    res_o   = '0;
    unique case (state_q)
      I_IDLE:   if (start_i) state_d = I_AREA_A;
      I_AREA_A: state_d = I_AREA_B;
      I_AREA_B: state_d = I_INTER;
      I_INTER:  state_d = I_UNION;
      I_UNION:  state_d = I_PROD;
      I_PROD:   state_d = I_CMP;
      I_CMP: begin
        res_o.done = 1'b1;
        // no overlap only counts at a zero threshold
        res_o.hit  = (inter_q == '0) ? (thr_i == '0)
                                     : ({2'b0, inter_q, 10'b0} >= prod_q);
        state_d    = I_IDLE;
      end
      default:  state_d = I_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= I_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == I_AREA_A) area_a_q <= mul_p[AREA_W-1:0];
    if (state_q == I_AREA_B) area_b_q <= mul_p[AREA_W-1:0];
    if (state_q == I_INTER)  inter_q  <= mul_p[AREA_W-1:0];
    if (state_q == I_UNION)
      union_q <= UNION_W'(area_a_q) + UNION_W'(area_b_q) - UNION_W'(inter_q);
    if (state_q == I_PROD)   prod_q   <= mul_p[PROD_W-1:0];
  end

endmodule

>>> hdl/greedy_box_suppression_top.sv
// Load: each held entry of lower score than the item moves up one place, working down
//   from the last, in the one-read, one-write store; the item then takes the freed place.
// Final item: entries are examined in order and an unmarked one is kept; later entries are
//   scanned and each unmarked one gets an overlap test on the shared multiplier; results leave one at a time.
// Reset (asynchronous, active low) clears counts, control and the threshold (461);
//   the box store is not cleared and needs no clearing pass.
module greedy_box_suppression_top
  import gbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // score[15:0], label[17:16], left[33:18], top[49:34], right[65:50], bottom[81:66]
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // kept_label[1:0], kept_score[17:2], kept_left[33:18], kept_top[49:34],
  // kept_right[65:50], kept_bottom[81:66]
  output logic [TDATA_W-1:0] m_axis_tdata,
  // valid_res[0]
  output logic               m_axis_tuser,
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [THR_W-1:0]   cfg_data_i
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_IRD   = 11'b00000000010,
    S_ICMP  = 11'b00000000100,
    S_PLACE = 11'b00000001000,
    S_SRD   = 11'b00000010000,
    S_SCHK  = 11'b00000100000,
    S_SKEEP = 11'b00001000000,
    S_JRD   = 11'b00010000000,
    S_JCHK  = 11'b00100000000,
    S_JWAIT = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0]  thr_q;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  place_q, place_d;
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d;
  logic [KEPT_W-1:0] n_q, n_d;
  logic              pend_q, pend_d;
  entry_t            pend_ent_q, pend_ent_d;
  entry_t            new_ent_q, cand_q;
  logic              new_last_q;
  box_t              bj_q;

  entry_t ent_mem [CAPACITY];
  logic   mark_mem [CAPACITY];
  entry_t rd_ent_q;
  logic   rd_mark_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic   ent_we, mark_we, mark_wd;
  entry_t ent_wd;

  logic   out_valid_q, out_user_q, out_last_q;
  entry_t out_ent_q;
  logic   out_free, out_load, out_user_d, out_last_d;
  entry_t out_ent_d;

  logic     in_acc, iou_start;
  iou_res_t iou_res;
  entry_t   in_ent;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_ent.score      = s_axis_tdata[15:0];
  assign in_ent.label      = s_axis_tdata[17:16];
  assign in_ent.box.left   = s_axis_tdata[33:18];
  assign in_ent.box.top    = s_axis_tdata[49:34];
  assign in_ent.box.right  = s_axis_tdata[65:50];
  assign in_ent.box.bottom = s_axis_tdata[81:66];

  gbs_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iou_start),
    .thr_i   (thr_q),
    .box_a_i (pend_ent_q.box),
    .box_b_i (bj_q),
    .res_o   (iou_res)
  );

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    k_d        = k_q;
    place_d    = place_q;
    i_d        = i_q;
    j_d        = j_q;
    n_d        = n_q;
    pend_d     = pend_q;
    pend_ent_d = pend_ent_q;
    rd_addr    = i_q[IDX_W-1:0];
    wr_addr    = k_q + IDX_W'(1);
    ent_we     = 1'b0;
    ent_wd     = rd_ent_q;
    mark_we    = 1'b0;
    mark_wd    = 1'b0;
    iou_start  = 1'b0;
    out_load   = 1'b0;
    out_ent_d  = pend_ent_q;
    out_user_d = 1'b1;
    out_last_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = IDX_W'(held_q - CNT_W'(1));
        if (in_acc) begin
          if (held_q == '0) begin
            place_d = '0;
            state_d = S_PLACE;
          end else begin
            k_d     = IDX_W'(held_q - CNT_W'(1));
            state_d = S_ICMP;
          end
        end
      end
      S_IRD: begin
        rd_addr = k_q;
        state_d = S_ICMP;
      end
      S_ICMP: begin
        if (rd_ent_q.score < new_ent_q.score) begin
          // move entry up one place; the last place of a full store drops off
          ent_we  = (CNT_W'(k_q) != CNT_W'(CAPACITY - 1));
          mark_we = ent_we;
          if (k_q == '0) begin
            place_d = '0;
            state_d = S_PLACE;
          end else begin
            k_d     = k_q - IDX_W'(1);
            state_d = S_IRD;
          end
        end else begin
          place_d = CNT_W'(k_q) + CNT_W'(1);
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        wr_addr = place_q[IDX_W-1:0];
        ent_wd  = new_ent_q;
        ent_we  = (place_q < CNT_W'(CAPACITY));
        mark_we = ent_we;
        if (held_q != CNT_W'(CAPACITY)) held_d = held_q + CNT_W'(1);
        if (new_last_q) begin
          i_d     = '0;
          n_d     = '0;
          pend_d  = 1'b0;
          state_d = S_SRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SRD: begin
        if (i_q >= held_q) state_d = S_FIN;
        else               state_d = S_SCHK;
      end
      S_SCHK: begin
        if (rd_mark_q) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_SRD;
        end else begin
          state_d = S_SKEEP;
        end
      end
      S_SKEEP: begin
        if (!pend_q || out_free) begin
          out_load   = pend_q;
          pend_d     = 1'b1;
          pend_ent_d = cand_q;
          n_d        = n_q + KEPT_W'(1);
          if (n_q == KEPT_W'(MAX_KEPT - 1)) begin
            state_d = S_FIN;
          end else begin
            j_d     = i_q + CNT_W'(1);
            state_d = S_JRD;
          end
        end
      end
      S_JRD: begin
        rd_addr = j_q[IDX_W-1:0];
        if (j_q >= held_q) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_SRD;
        end else begin
          state_d = S_JCHK;
        end
      end
      S_JCHK: begin
        if (rd_mark_q) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_JRD;
        end else begin
          iou_start = 1'b1;
          state_d   = S_JWAIT;
        end
      end
      S_JWAIT: begin
        wr_addr = j_q[IDX_W-1:0];
        if (iou_res.done) begin
          mark_we = iou_res.hit;
          mark_wd = 1'b1;
          j_d     = j_q + CNT_W'(1);
          state_d = S_JRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          out_user_d = pend_q;
          out_ent_d  = pend_q ? pend_ent_q : '0;
          held_d     = '0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we)  ent_mem[wr_addr]  <= ent_wd;
    if (mark_we) mark_mem[wr_addr] <= mark_wd;
    rd_ent_q  <= ent_mem[rd_addr];
    rd_mark_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= THR_RESET;
      held_q      <= '0;
      k_q         <= '0;
      place_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      held_q  <= held_d;
      k_q     <= k_d;
      place_q <= place_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
      if (out_load)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ent_q <= pend_ent_d;
    if (in_acc) begin
      new_ent_q  <= in_ent;
      new_last_q <= s_axis_tlast;
    end
    if (state_q == S_SCHK) cand_q <= rd_ent_q;
    if (state_q == S_JCHK) bj_q   <= rd_ent_q.box;
    if (out_load) begin
      out_ent_q  <= out_ent_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'b0, out_ent_q.box.bottom, out_ent_q.box.right, out_ent_q.box.top,
                          out_ent_q.box.left, out_ent_q.score, out_ent_q.label};

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= KEPT_W'(MAX_KEPT))
    else $error("kept count above limit");
  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (held_q == '0 && state_q == S_IDLE))
    else $error("frame not cleared after last result");
  a_last_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !out_last_d) |-> (state_q == S_SKEEP && pend_q))
    else $error("result loaded outside keep step");
`endif

endmodule
